FILE: sv/spi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spi_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned ProdW  = 2 * CoordW;
  localparam int unsigned DistW  = ProdW + 3;
  localparam int unsigned DenW   = DistW - 1;
  localparam int unsigned NumW   = CoordW + ProdW;
  localparam int unsigned DivW   = NumW + 1;
  localparam int unsigned QuotW  = CoordW;
  localparam int unsigned FracW  = 16;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
    logic signed [CoordW-1:0] normal_x;
    logic signed [CoordW-1:0] normal_y;
    logic signed [CoordW-1:0] normal_z;
    logic signed [CoordW-1:0] plane_offset;
  } in_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] cross_x;
    logic signed [CoordW-1:0] cross_y;
    logic signed [CoordW-1:0] cross_z;
  } out_t;

  typedef struct packed {
    logic                   hit;
    logic [2:0]             neg;
    logic [2:0][CoordW-1:0] ad;
    logic [ProdW-1:0]       mag0;
    logic [DenW-1:0]        den;
    logic [2:0][CoordW-1:0] start;
  } dist_t;

  typedef struct packed {
    logic                   hit;
    logic [2:0]             neg;
    logic [DenW-1:0]        den;
    logic [2:0][CoordW-1:0] start;
    logic [2:0][NumW-1:0]   num;
    logic [2:0][QuotW-1:0]  quot;
  } div_t;

endpackage
`default_nettype wire

FILE: sv/spi_dist.sv
`timescale 1ns / 1ps
`default_nettype none
module spi_dist (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  spi_pkg::in_t  data_i,
  output logic          valid_o,
  output spi_pkg::dist_t data_o
);
  import spi_pkg::*;

  logic [2:0] vld_q;

  logic [2:0][ProdW-1:0]  p0_q, p1_q;
  logic [2:0][CoordW:0]   dlt_q, dlt2_q;
  logic [2:0][CoordW-1:0] st_q, st2_q;
  logic [CoordW-1:0]      k_q;
  logic [DistW-1:0]       d0_q, d1_q;
  dist_t                  res_q;

  logic signed [CoordW-1:0] s_c [3];
  logic signed [CoordW-1:0] e_c [3];
  logic signed [CoordW-1:0] n_c [3];

  logic signed [DistW-1:0] d0_d, d1_d, kk;
  logic signed [DistW-1:0] df;
  dist_t                   res_d;

  always_comb begin
    s_c[0] = data_i.start_x;  s_c[1] = data_i.start_y;  s_c[2] = data_i.start_z;
    e_c[0] = data_i.end_x;    e_c[1] = data_i.end_y;    e_c[2] = data_i.end_z;
    n_c[0] = data_i.normal_x; n_c[1] = data_i.normal_y; n_c[2] = data_i.normal_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        p0_q[i]  <= ProdW'(n_c[i] * s_c[i]);
        p1_q[i]  <= ProdW'(n_c[i] * e_c[i]);
        dlt_q[i] <= (CoordW+1)'($signed({e_c[i][CoordW-1], e_c[i]})
                    - $signed({s_c[i][CoordW-1], s_c[i]}));
        st_q[i]  <= s_c[i];
      end
      k_q <= data_i.plane_offset;
    end
  end

  always_comb begin
    kk   = $signed({{(DistW-CoordW-FracW){k_q[CoordW-1]}}, k_q, {FracW{1'b0}}});
    d0_d = -kk;
    d1_d = -kk;
    for (int i = 0; i < 3; i++) begin
      d0_d = d0_d + DistW'($signed(p0_q[i]));
      d1_d = d1_d + DistW'($signed(p1_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d0_q   <= d0_d;
      d1_q   <= d1_d;
      dlt2_q <= dlt_q;
      st2_q  <= st_q;
    end
  end

  always_comb begin
    logic signed [DistW-1:0] a0;
    logic signed [CoordW:0]  dl;
    a0 = $signed(d0_q);
    df = $signed(d0_q) - $signed(d1_q);
    if (df[DistW-1]) df = -df;
    if (a0[DistW-1]) a0 = -a0;
    res_d.hit = (d0_q[DistW-1] && !d1_q[DistW-1] && (d1_q != '0))
             || (!d0_q[DistW-1] && d1_q[DistW-1]);
    res_d.den  = df[DenW-1:0];
    res_d.mag0 = a0[ProdW-1:0];
    for (int i = 0; i < 3; i++) begin
      dl = $signed(dlt2_q[i]);
      res_d.neg[i] = dl[CoordW];
      if (dl[CoordW]) dl = -dl;
      res_d.ad[i] = dl[CoordW-1:0];
    end
    res_d.start = st2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = vld_q[2];
  assign data_o  = res_q;

endmodule
`default_nettype wire

FILE: sv/spi_scale.sv
`timescale 1ns / 1ps
`default_nettype none
module spi_scale (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  spi_pkg::dist_t data_i,
  output logic           valid_o,
  output spi_pkg::div_t  data_o
);
  import spi_pkg::*;

  logic [1:0] vld_q;
  logic [2:0][ProdW-1:0] lo_q, hi_q;
  dist_t  dist_q;
  div_t   res_q;
  div_t   res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= ProdW'(data_i.ad[i]) * ProdW'(data_i.mag0[CoordW-1:0]);
        hi_q[i] <= ProdW'(data_i.ad[i]) * ProdW'(data_i.mag0[ProdW-1:CoordW]);
      end
      dist_q <= data_i;
    end
  end

  always_comb begin
    res_d.hit   = dist_q.hit;
    res_d.neg   = dist_q.neg;
    res_d.den   = dist_q.den;
    res_d.start = dist_q.start;
    res_d.quot  = '0;
    for (int i = 0; i < 3; i++) begin
      res_d.num[i] = NumW'(lo_q[i]) + {hi_q[i], {CoordW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = vld_q[1];
  assign data_o  = res_q;

endmodule
`default_nettype wire

FILE: sv/spi_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module spi_div_stage #(
  parameter int unsigned Bit = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  spi_pkg::div_t data_i,
  output logic          valid_o,
  output spi_pkg::div_t data_o
);
  import spi_pkg::*;

  logic  vld_q;
  div_t  res_q;
  div_t  res_d;
  logic [DivW-1:0] trial;

  always_comb begin
    res_d = data_i;
    trial = DivW'(data_i.den) << Bit;
    for (int i = 0; i < 3; i++) begin
      if (DivW'(data_i.num[i]) >= trial) begin
        res_d.num[i]       = NumW'(DivW'(data_i.num[i]) - trial);
        res_d.quot[i][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = res_q;

endmodule
`default_nettype wire

FILE: sv/segment_plane_intersect.sv
`timescale 1ns / 1ps
`default_nettype none
// Segment against plane crossing test in Q16.16 fixed point. One transaction enters every
// clock cycle while the pipeline advances: three stages form the exact plane
// distances, two form the scaled numerators, one restoring divider stage per quotient bit
// (32 of them) yields the offset from the start point along all three axes, and a final
// stage forms the crossing point. An output stall holds the whole pipeline while a result
// is waiting, so the input channel stalls only while a finished result is waiting to be taken.
module segment_plane_intersect (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spi_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output spi_pkg::out_t out_data_o
);
  import spi_pkg::*;

  logic  adv;
  logic  dist_vld, scale_vld;
  dist_t dist_data;

  logic  div_vld  [QuotW+1];
  div_t  div_data [QuotW+1];

  logic  out_vld_q;
  out_t  out_q, out_d;

  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  spi_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (dist_vld),
    .data_o  (dist_data)
  );

  spi_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dist_vld),
    .data_i  (dist_data),
    .valid_o (scale_vld),
    .data_o  (div_data[0])
  );

  assign div_vld[0] = scale_vld;

  for (genvar g = 0; g < QuotW; g++) begin : g_div
    spi_div_stage #(
      .Bit (QuotW - 1 - g)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (div_vld[g]),
      .data_i  (div_data[g]),
      .valid_o (div_vld[g+1]),
      .data_o  (div_data[g+1])
    );
  end

  always_comb begin
    logic [2:0][CoordW-1:0] pt;
    for (int i = 0; i < 3; i++) begin
      if (div_data[QuotW].neg[i]) begin
        pt[i] = div_data[QuotW].start[i] - div_data[QuotW].quot[i];
      end else begin
        pt[i] = div_data[QuotW].start[i] + div_data[QuotW].quot[i];
      end
      if (!div_data[QuotW].hit) pt[i] = '0;
    end
    out_d.hit     = div_data[QuotW].hit;
    out_d.cross_x = pt[0];
    out_d.cross_y = pt[1];
    out_d.cross_z = pt[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= div_vld[QuotW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |->
      (out_data_o.cross_x == '0 && out_data_o.cross_y == '0 && out_data_o.cross_z == '0))
    else $error("miss transaction carries a non-zero point");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  a_held_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("waiting result lost or changed");

endmodule
`default_nettype wire

FILE: sim/segment_plane_intersect_tb.sv
`timescale 1ns / 1ps
module segment_plane_intersect_tb;
  import spi_pkg::*;

  typedef struct {
    in_t  stim;
    bit   fixed;
    out_t want;
  } vector_t;

  localparam int NumRandom = 630;
  localparam int StallPct  = 21;
  localparam int HoldCycles = 300;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles = 60;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  out_t crossings_due[$];
  int   failures;
  int   quiet_cycles;
  bit   calm;
  bit   hold_request;

  segment_plane_intersect uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic out_t crossing_point(in_t t);
    logic signed [127:0] d0;
    logic signed [127:0] d1;
    logic signed [127:0] gap;
    logic [127:0] den;
    logic [127:0] mag0;
    logic [127:0] q;
    logic signed [31:0] s [3];
    logic signed [31:0] e [3];
    logic signed [32:0] delta;
    logic [32:0] ad;
    logic signed [63:0] off;
    logic signed [63:0] pt [3];
    out_t r;
    s[0] = t.start_x; s[1] = t.start_y; s[2] = t.start_z;
    e[0] = t.end_x;   e[1] = t.end_y;   e[2] = t.end_z;
    d0 = t.normal_x * t.start_x + t.normal_y * t.start_y + t.normal_z * t.start_z
         - (t.plane_offset <<< FracW);
    d1 = t.normal_x * t.end_x + t.normal_y * t.end_y + t.normal_z * t.end_z
         - (t.plane_offset <<< FracW);
    r = '0;
    r.hit = (d0 < 0 && d1 > 0) || (d0 >= 0 && d1 < 0);
    if (r.hit) begin
      gap  = d0 - d1;
      den  = gap < 0 ? -gap : gap;
      mag0 = d0 < 0 ? -d0 : d0;
      for (int i = 0; i < 3; i++) begin
        delta = $signed({e[i][31], e[i]}) - $signed({s[i][31], s[i]});
        ad = delta < 0 ? -delta : delta;
        q = ({95'd0, ad} * mag0) / den;
        off = delta < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
        pt[i] = s[i] + off;
      end
      r.cross_x = pt[0][31:0];
      r.cross_y = pt[1][31:0];
      r.cross_z = pt[2][31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] near(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic in_t random_segment();
    in_t t;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 3) begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      t.normal_x = near(1 << 18);
      t.normal_y = near(1 << 18);
      t.normal_z = near(1 << 18);
      t.start_x  = near(1 << 24);
      t.start_y  = near(1 << 24);
      t.start_z  = near(1 << 24);
      t.end_x    = -t.start_x + near(1 << 12);
      t.end_y    = -t.start_y + near(1 << 12);
      t.end_z    = -t.start_z + near(1 << 12);
      t.plane_offset = (mode == 9) ? $urandom : near(1 << 10);
    end
    return t;
  endfunction

  task automatic offer(in_t t);
    if (!calm && $urandom_range(0, 99) < StallPct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 40);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic check_crossing(out_t want, out_t got);
    if (got.hit !== want.hit) begin
      $error("hit: expected %0d, got %0d", want.hit, got.hit);
      failures++;
    end
    if (got.cross_x !== want.cross_x) begin
      $error("cross_x: expected %0d, got %0d", want.cross_x, got.cross_x);
      failures++;
    end
    if (got.cross_y !== want.cross_y) begin
      $error("cross_y: expected %0d, got %0d", want.cross_y, got.cross_y);
      failures++;
    end
    if (got.cross_z !== want.cross_z) begin
      $error("cross_z: expected %0d, got %0d", want.cross_z, got.cross_z);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (crossings_due.size() == 0) begin
        $error("result transaction with nothing expected");
        failures++;
      end else begin
        check_crossing(crossings_due.pop_front(), out_data_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit held;
    held = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= !calm && $urandom_range(0, 99) < StallPct;
    end
  end

  initial begin
    vector_t vectors [$];
    in_t t;
    out_t z;
    z = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    rst_ni       = 1'b0;
    calm         = 1'b0;
    hold_request = 1'b0;

    t = '0;
    vectors.push_back('{t, 1'b1, z});
    t.plane_offset = 32'sh0001_0000;
    t.end_z = 32'sh7fff_ffff;
    vectors.push_back('{t, 1'b1, z});
    t = '0;
    t.normal_z = 32'sh0001_0000;
    t.start_x = 32'sh0003_0000; t.start_z = 32'sh0000_0000; t.end_z = -32'sh0002_0000;
    vectors.push_back('{t, 1'b1, '{1'b1, 32'sh0003_0000, 32'sh0, 32'sh0}});
    t.start_z = -32'sh0002_0000; t.end_z = 32'sh0000_0000;
    vectors.push_back('{t, 1'b1, z});
    t.start_z = 32'sh0; t.end_x = 32'sh0005_0000;
    vectors.push_back('{t, 1'b1, z});
    t.start_z = 32'sh0001_0000; t.end_z = 32'sh0004_0000;
    vectors.push_back('{t, 1'b1, z});
    t.start_z = -32'sh0001_0000; t.end_z = 32'sh0001_0000;
    vectors.push_back('{t, 1'b0, z});
    t.start_z = 32'sh0001_0000; t.end_z = -32'sh0003_0000; t.end_y = -32'sh0007_0001;
    vectors.push_back('{t, 1'b0, z});
    t = {10{32'sh7fff_ffff}};
    vectors.push_back('{t, 1'b0, z});
    t = {10{32'sh8000_0000}};
    vectors.push_back('{t, 1'b0, z});
    t = {{3{32'sh7fff_ffff}}, {3{32'sh8000_0000}}, {3{32'sh7fff_ffff}}, 32'sh0};
    vectors.push_back('{t, 1'b0, z});
    t = {{3{32'sh8000_0000}}, {3{32'sh7fff_ffff}}, {3{32'sh8000_0000}}, 32'sh7fff_ffff};
    vectors.push_back('{t, 1'b0, z});
    t = {{3{32'sh8000_0000}}, {3{32'sh7fff_ffff}}, {3{32'sh7fff_ffff}}, 32'sh8000_0000};
    vectors.push_back('{t, 1'b0, z});
    t = {{3{32'sh7fff_ffff}}, {3{32'sh8000_0000}}, 32'sh1, 32'sh0, 32'sh0, 32'sh0};
    vectors.push_back('{t, 1'b0, z});
    t = {{3{32'sh0000_0001}}, {3{-32'sh0000_0001}}, {3{32'sh7fff_ffff}}, 32'sh0};
    vectors.push_back('{t, 1'b0, z});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vectors[i]) begin
      offer(vectors[i].stim);
      crossings_due.push_back(vectors[i].fixed ? vectors[i].want
                                               : crossing_point(vectors[i].stim));
    end

    for (int n = 0; n < NumRandom; n++) begin
      calm = (n >= 100 && n < 250);
      if (n == 350) hold_request = 1'b1;
      t = random_segment();
      offer(t);
      crossings_due.push_back(crossing_point(t));
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (crossings_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
